### rtl/bdq_pkg.sv
package bdq_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_CAPACITY  = 16;
    localparam int DEF_NAME_BITS = 64;

    // Fixed port widths
    localparam int OP_W        = 3;
    localparam int NAME_PORT_W = 64;
    localparam int ID_W        = 32;
    localparam int STAT_W      = 2;

    // Operation codes
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_REAR  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_REAR   = 3'd3;
    localparam logic [OP_W-1:0] OP_DUMP_FWD   = 3'd4;
    localparam logic [OP_W-1:0] OP_DUMP_BWD   = 3'd5;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    // Commands from controller to datapath
    typedef struct packed {
        logic              push_front;
        logic              push_rear;
        logic              pop_front;
        logic              pop_rear;
        logic              dump_fwd;
        logic              dump_bwd;
        logic              dump_rd;
        logic              dump_adv;
        logic              out_mem;
        logic              out_stat;
        logic              out_last;
        logic [STAT_W-1:0] stat_code;
    } dp_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic empty;
        logic full;
        logic dump_end;
        logic out_busy;
    } dp_stat_t;

endpackage

### rtl/bounded_deque_with_dump_unit.sv
// Bounded double-ended queue of CAPACITY entries (name tag of NAME_BITS bits plus a
// 32-bit id) kept in a ring buffer in one registered-read RAM. Opcodes push or pop at
// either end, or dump all entries front-to-rear or rear-to-front with m_last on the
// final result. Pushes and status-only results (full, empty) appear in the cycle after
// the transfer; a pop first reads the RAM, then loads the result register; a dump
// reads each stored entry from the RAM in turn and loads it once the result register
// is free. One item is in work at a time: s_ready rises again once the item's last
// result has been taken, so the rate is bounded by the RAM read and the single result
// register. Opcodes 6 and 7 are accepted and dropped without a result. Names are
// stored truncated to NAME_BITS and returned zero-extended.
module bounded_deque_with_dump_unit
    import bdq_pkg::*;
#(
    parameter int CAPACITY  = DEF_CAPACITY,
    parameter int NAME_BITS = DEF_NAME_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [OP_W-1:0]        s_opcode,
    input  logic [NAME_PORT_W-1:0] s_entry_name,
    input  logic signed [ID_W-1:0] s_entry_id,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [STAT_W-1:0]      m_status,
    output logic [NAME_PORT_W-1:0] m_out_name,
    output logic signed [ID_W-1:0] m_out_id,
    output logic                   m_last
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    bdq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_opcode (s_opcode),
        .stat     (stat),
        .s_ready  (s_ready),
        .cmd      (cmd)
    );

    bdq_dp #(
        .CAPACITY  (CAPACITY),
        .NAME_BITS (NAME_BITS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .s_entry_name (s_entry_name),
        .s_entry_id   (s_entry_id),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_out_name   (m_out_name),
        .m_out_id     (m_out_id),
        .m_last       (m_last)
    );

`ifndef ASSERT_OFF
    // Never overwrite a result that has not been transferred
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_mem || cmd.out_stat) |-> !stat.out_busy)
        else $error("result register loaded while still occupied");

    // A push always answers in the next cycle with a final result
    a_push_answer: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_opcode == OP_PUSH_FRONT || s_opcode == OP_PUSH_REAR))
        |=> (m_valid && m_last))
        else $error("push did not produce a final result");

    // Error results are always the only result of their item
    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != STAT_OK) |-> m_last)
        else $error("error status without last");

    // Full and empty cannot hold together
    a_full_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !(stat.full && stat.empty))
        else $error("queue reported both full and empty");
`endif

endmodule

### rtl/bdq_ram.sv
module bdq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/bdq_ctrl.sv
module bdq_ctrl
    import bdq_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    input  logic [OP_W-1:0] s_opcode,
    input  dp_stat_t        stat,
    output logic            s_ready,
    output dp_cmd_t         cmd
);

    localparam logic [1:0] ST_IDLE     = 2'd0;
    localparam logic [1:0] ST_POP      = 2'd1;
    localparam logic [1:0] ST_DUMP_RD  = 2'd2;
    localparam logic [1:0] ST_DUMP_OUT = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       accept;

    // Take a new item only when idle and the result register is free
    assign s_ready = (state_reg == ST_IDLE) && !stat.out_busy;
    assign accept  = s_valid && s_ready;

    // Decode operations and sequence pops and dumps
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_opcode)
                        OP_PUSH_FRONT, OP_PUSH_REAR: begin
                            cmd.out_stat = 1'b1;
                            cmd.out_last = 1'b1;
                            if (stat.full) begin
                                cmd.stat_code = STAT_FULL;
                            end else begin
                                cmd.stat_code  = STAT_OK;
                                cmd.push_front = (s_opcode == OP_PUSH_FRONT);
                                cmd.push_rear  = (s_opcode == OP_PUSH_REAR);
                            end
                        end
                        OP_POP_FRONT, OP_POP_REAR: begin
                            if (stat.empty) begin
                                cmd.out_stat  = 1'b1;
                                cmd.out_last  = 1'b1;
                                cmd.stat_code = STAT_EMPTY;
                            end else begin
                                cmd.pop_front = (s_opcode == OP_POP_FRONT);
                                cmd.pop_rear  = (s_opcode == OP_POP_REAR);
                                state_next    = ST_POP;
                            end
                        end
                        OP_DUMP_FWD, OP_DUMP_BWD: begin
                            if (stat.empty) begin
                                cmd.out_stat  = 1'b1;
                                cmd.out_last  = 1'b1;
                                cmd.stat_code = STAT_EMPTY;
                            end else begin
                                cmd.dump_fwd = (s_opcode == OP_DUMP_FWD);
                                cmd.dump_bwd = (s_opcode == OP_DUMP_BWD);
                                state_next   = ST_DUMP_RD;
                            end
                        end
                        default: begin
                            // unused opcodes are dropped
                        end
                    endcase
                end
            end
            ST_POP: begin
                cmd.out_mem  = 1'b1;
                cmd.out_last = 1'b1;
                state_next   = ST_IDLE;
            end
            ST_DUMP_RD: begin
                cmd.dump_rd = 1'b1;
                state_next  = ST_DUMP_OUT;
            end
            ST_DUMP_OUT: begin
                // wait for the result register, then advance or finish
                if (!stat.out_busy) begin
                    cmd.out_mem  = 1'b1;
                    cmd.out_last = stat.dump_end;
                    if (stat.dump_end) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.dump_adv = 1'b1;
                        state_next   = ST_DUMP_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/bdq_dp.sv
module bdq_dp
    import bdq_pkg::*;
#(
    parameter int CAPACITY  = DEF_CAPACITY,
    parameter int NAME_BITS = DEF_NAME_BITS
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  dp_cmd_t                  cmd,
    output dp_stat_t                 stat,
    input  logic [NAME_PORT_W-1:0]   s_entry_name,
    input  logic signed [ID_W-1:0]   s_entry_id,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [STAT_W-1:0]        m_status,
    output logic [NAME_PORT_W-1:0]   m_out_name,
    output logic signed [ID_W-1:0]   m_out_id,
    output logic                     m_last
);

    localparam int IDX_W   = $clog2(CAPACITY);
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int ENTRY_W = NAME_BITS + ID_W;

    localparam logic [IDX_W:0]   SUM_CAP = (IDX_W + 1)'(CAPACITY);
    localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(CAPACITY - 1);
    localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(CAPACITY);

    logic [IDX_W-1:0] front_reg, front_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             bwd_reg, bwd_next;

    logic                   m_valid_reg, m_valid_next;
    logic [STAT_W-1:0]      status_reg, status_next;
    logic [NAME_PORT_W-1:0] name_reg, name_next;
    logic [ID_W-1:0]        id_reg, id_next;
    logic                   last_reg, last_next;

    logic [IDX_W-1:0]   front_dec;
    logic [CNT_W-1:0]   cnt_m1;
    logic [CNT_W-1:0]   back_off;
    logic               ram_we, ram_re;
    logic [IDX_W-1:0]   ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

    // Ring position: (base + off) mod CAPACITY, both below CAPACITY
    function automatic logic [IDX_W-1:0] slot_add(input logic [IDX_W-1:0] base,
                                                  input logic [IDX_W-1:0] off);
        logic [IDX_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= SUM_CAP) begin
            sum = sum - SUM_CAP;
        end
        return sum[IDX_W-1:0];
    endfunction

    assign front_dec = (front_reg == '0) ? IDX_TOP : front_reg - IDX_W'(1);
    assign cnt_m1    = count_reg - CNT_W'(1);
    assign back_off  = cnt_m1 - CNT_W'(idx_reg);

    assign stat.empty    = (count_reg == '0);
    assign stat.full     = (count_reg >= CNT_CAP);
    assign stat.dump_end = (CNT_W'(idx_reg) == cnt_m1);
    assign stat.out_busy = m_valid_reg;

    // Store access
    assign ram_we    = cmd.push_front || cmd.push_rear;
    assign ram_waddr = cmd.push_front ? front_dec
                                      : slot_add(front_reg, count_reg[IDX_W-1:0]);
    assign ram_wdata = {s_entry_name[NAME_BITS-1:0], s_entry_id};
    assign ram_re    = cmd.pop_front || cmd.pop_rear || cmd.dump_rd;

    always_comb begin
        if (cmd.pop_front) begin
            ram_raddr = front_reg;
        end else if (cmd.pop_rear) begin
            ram_raddr = slot_add(front_reg, cnt_m1[IDX_W-1:0]);
        end else if (bwd_reg) begin
            ram_raddr = slot_add(front_reg, back_off[IDX_W-1:0]);
        end else begin
            ram_raddr = slot_add(front_reg, idx_reg);
        end
    end

    bdq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Advance ring pointers and the dump walk
    always_comb begin
        front_next = front_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        bwd_next   = bwd_reg;
        if (cmd.push_front) begin
            front_next = front_dec;
        end
        if (cmd.pop_front) begin
            front_next = slot_add(front_reg, IDX_W'(1));
        end
        if (cmd.push_front || cmd.push_rear) begin
            count_next = count_reg + CNT_W'(1);
        end
        if (cmd.pop_front || cmd.pop_rear) begin
            count_next = cnt_m1;
        end
        if (cmd.dump_fwd || cmd.dump_bwd) begin
            idx_next = '0;
            bwd_next = cmd.dump_bwd;
        end
        if (cmd.dump_adv) begin
            idx_next = idx_reg + IDX_W'(1);
        end
    end

    // Load the result register, drop it once the transfer completes
    always_comb begin
        m_valid_next = m_valid_reg;
        status_next  = status_reg;
        name_next    = name_reg;
        id_next      = id_reg;
        last_next    = last_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.out_stat) begin
            m_valid_next = 1'b1;
            status_next  = cmd.stat_code;
            name_next    = '0;
            id_next      = '0;
            last_next    = cmd.out_last;
        end else if (cmd.out_mem) begin
            m_valid_next               = 1'b1;
            status_next                = STAT_OK;
            name_next                  = '0;
            name_next[NAME_BITS-1:0]   = ram_rdata[ENTRY_W-1:ID_W];
            id_next                    = ram_rdata[ID_W-1:0];
            last_next                  = cmd.out_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg   <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            front_reg   <= front_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        bwd_reg    <= bwd_next;
        status_reg <= status_next;
        name_reg   <= name_next;
        id_reg     <= id_next;
        last_reg   <= last_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_status   = status_reg;
    assign m_out_name = name_reg;
    assign m_out_id   = signed'(id_reg);
    assign m_last     = last_reg;

endmodule

### verif/bounded_deque_with_dump_unit_tb.sv
`timescale 1ns / 100ps

module bounded_deque_with_dump_unit_tb;
    import bdq_pkg::*;

    // Opcodes the block drops without a result
    localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

    localparam int CAP = DEF_CAPACITY;
    localparam logic [NAME_PORT_W-1:0] NAME_KEEP =
        {NAME_PORT_W{1'b1}} >> (NAME_PORT_W - DEF_NAME_BITS);
    localparam int RANDOM_ITEMS = 250;

    typedef struct {
        logic [OP_W-1:0]        op;
        logic [NAME_PORT_W-1:0] name;
        logic signed [ID_W-1:0] id;
        bit                     drain_first;
    } deque_cmd_t;

    typedef struct {
        logic [STAT_W-1:0]      status;
        logic [NAME_PORT_W-1:0] name;
        logic signed [ID_W-1:0] id;
        logic                   last;
    } deque_result_t;

    logic                   aclk;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [OP_W-1:0]        s_opcode = OP_PUSH_FRONT;
    logic [NAME_PORT_W-1:0] s_entry_name = '0;
    logic signed [ID_W-1:0] s_entry_id = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [STAT_W-1:0]      m_status;
    logic [NAME_PORT_W-1:0] m_out_name;
    logic signed [ID_W-1:0] m_out_id;
    logic                   m_last;

    // Stimulus and expected results
    deque_cmd_t    cmd_plan[$];
    deque_result_t awaited_results[$];
    int            accepted_items = 0;
    int            mismatches = 0;
    logic          calm;

    // Deque mirror
    logic [NAME_PORT_W-1:0] slot_name[CAP];
    logic signed [ID_W-1:0] slot_id[CAP];
    int                     head_slot = 0;
    int                     fill_level = 0;

    // Planner-side fill estimate and item count
    int plan_level = 0;
    int planned_items = 0;

    // Switch off idling on both sides for a stretch of transfers
    assign calm = (accepted_items >= 100) && (accepted_items < 150);

    bounded_deque_with_dump_unit uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_opcode     (s_opcode),
        .s_entry_name (s_entry_name),
        .s_entry_id   (s_entry_id),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_out_name   (m_out_name),
        .m_out_id     (m_out_id),
        .m_last       (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic void note_result(input logic [STAT_W-1:0] st,
                                        input logic [NAME_PORT_W-1:0] nm,
                                        input logic signed [ID_W-1:0] id,
                                        input logic lst);
        deque_result_t r;
        r.status = st;
        r.name   = nm;
        r.id     = id;
        r.last   = lst;
        awaited_results.push_back(r);
    endfunction

    // Update the mirror for one accepted item and queue the results it causes
    function automatic void apply_deque_op(input logic [OP_W-1:0] op,
                                           input logic [NAME_PORT_W-1:0] nm,
                                           input logic signed [ID_W-1:0] id);
        int slot;
        case (op)
            OP_PUSH_FRONT, OP_PUSH_REAR: begin
                if (fill_level >= CAP) begin
                    note_result(STAT_FULL, '0, '0, 1'b1);
                end else begin
                    if (op == OP_PUSH_FRONT) begin
                        head_slot = (head_slot + CAP - 1) % CAP;
                        slot = head_slot;
                    end else begin
                        slot = (head_slot + fill_level) % CAP;
                    end
                    slot_name[slot] = nm & NAME_KEEP;
                    slot_id[slot]   = id;
                    fill_level++;
                    note_result(STAT_OK, '0, '0, 1'b1);
                end
            end
            OP_POP_FRONT, OP_POP_REAR: begin
                if (fill_level == 0) begin
                    note_result(STAT_EMPTY, '0, '0, 1'b1);
                end else begin
                    if (op == OP_POP_FRONT) begin
                        slot = head_slot;
                        head_slot = (head_slot + 1) % CAP;
                    end else begin
                        slot = (head_slot + fill_level - 1) % CAP;
                    end
                    fill_level--;
                    note_result(STAT_OK, slot_name[slot], slot_id[slot], 1'b1);
                end
            end
            OP_DUMP_FWD, OP_DUMP_BWD: begin
                if (fill_level == 0) begin
                    note_result(STAT_EMPTY, '0, '0, 1'b1);
                end else begin
                    for (int i = 0; i < fill_level; i++) begin
                        slot = (op == OP_DUMP_FWD) ? (head_slot + i) % CAP
                                                   : (head_slot + fill_level - 1 - i) % CAP;
                        note_result(STAT_OK, slot_name[slot], slot_id[slot],
                                    i == fill_level - 1);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    task automatic plan_item(input logic [OP_W-1:0] op,
                             input logic [NAME_PORT_W-1:0] nm,
                             input logic signed [ID_W-1:0] id);
        deque_cmd_t c;
        c.op = op;
        c.name = nm;
        c.id = id;
        c.drain_first = 1'b0;
        cmd_plan.push_back(c);
        case (op)
            OP_PUSH_FRONT, OP_PUSH_REAR: if (plan_level < CAP) plan_level++;
            OP_POP_FRONT, OP_POP_REAR:   if (plan_level > 0) plan_level--;
            default: ;
        endcase
        if (op <= OP_DUMP_BWD) planned_items++;
    endtask

    task automatic plan_random(input logic [OP_W-1:0] op);
        plan_item(op, {$urandom, $urandom}, $urandom);
    endtask

    task automatic plan_drain_pause();
        deque_cmd_t c;
        c.op = OP_PUSH_FRONT;
        c.name = '0;
        c.id = '0;
        c.drain_first = 1'b1;
        cmd_plan.push_back(c);
    endtask

    function automatic logic [OP_W-1:0] any_push();
        return $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_REAR;
    endfunction

    function automatic logic [OP_W-1:0] any_pop();
        return $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_REAR;
    endfunction

    function automatic logic [OP_W-1:0] any_dump();
        return $urandom_range(0, 1) ? OP_DUMP_FWD : OP_DUMP_BWD;
    endfunction

    // Drive the input channel from the plan
    always @(posedge aclk) begin : driver_proc
        deque_cmd_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                apply_deque_op(s_opcode, s_entry_name, s_entry_id);
                accepted_items++;
            end
            if (!s_valid || s_ready) begin
                if (cmd_plan.size() == 0) begin
                    s_valid <= 1'b0;
                end else if (cmd_plan[0].drain_first) begin
                    // Hold off until every expected result is out
                    if (awaited_results.size() == 0) cmd_plan.delete(0);
                    s_valid <= 1'b0;
                end else if (!calm && $urandom_range(0, 99) < 13) begin
                    s_valid <= 1'b0;
                end else begin
                    nxt = cmd_plan.pop_front();
                    s_valid      <= 1'b1;
                    s_opcode     <= nxt.op;
                    s_entry_name <= nxt.name;
                    s_entry_id   <= nxt.id;
                end
            end
        end
    end

    // Check each result transfer against the oldest expectation
    always @(posedge aclk) begin : monitor_proc
        deque_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (awaited_results.size() == 0) begin
                    $error("unexpected result: status %0d name %h id %0d last %0b",
                           m_status, m_out_name, m_out_id, m_last);
                    mismatches++;
                end else begin
                    want = awaited_results.pop_front();
                    if (m_status !== want.status) begin
                        $error("m_status: expected %0d, got %0d", want.status, m_status);
                        mismatches++;
                    end
                    if (m_out_name !== want.name) begin
                        $error("m_out_name: expected %h, got %h", want.name, m_out_name);
                        mismatches++;
                    end
                    if (m_out_id !== want.id) begin
                        $error("m_out_id: expected %0d, got %0d", want.id, m_out_id);
                        mismatches++;
                    end
                    if (m_last !== want.last) begin
                        $error("m_last: expected %0b, got %0b", want.last, m_last);
                        mismatches++;
                    end
                end
            end
            m_ready <= calm || ($urandom_range(0, 99) >= 13);
        end
    end

    initial begin
        int  mode;
        bit  mid_pause_done;
        mid_pause_done = 1'b0;

        // Empty-queue cases
        plan_random(OP_POP_FRONT);
        plan_random(OP_POP_REAR);
        plan_random(OP_DUMP_FWD);
        plan_random(OP_DUMP_BWD);
        // Field extremes at both ends
        plan_item(OP_PUSH_FRONT, '1, 32'sh8000_0000);
        plan_item(OP_PUSH_REAR, '0, 32'sh7fff_ffff);
        plan_item(OP_PUSH_FRONT, 64'h0123_4567_89ab_cdef, -1);
        plan_item(OP_PUSH_REAR, 64'h8000_0000_0000_0001, 0);
        plan_random(OP_DUMP_FWD);
        plan_random(OP_DUMP_BWD);
        plan_random(OP_SPARE_A);
        plan_random(OP_POP_FRONT);
        plan_random(OP_POP_REAR);
        plan_random(OP_SPARE_B);
        plan_random(OP_DUMP_FWD);
        plan_random(OP_POP_REAR);
        plan_random(OP_POP_FRONT);
        plan_random(OP_POP_FRONT);
        plan_random(OP_PUSH_REAR);
        plan_random(OP_DUMP_BWD);
        plan_drain_pause();

        // Fill past capacity once up front so the full case is always hit
        while (plan_level < CAP) plan_random(any_push());
        plan_random(any_push());
        plan_random(any_dump());

        // Random sequences: fill, drain, dumps, mixed runs and a little noise
        while (planned_items < RANDOM_ITEMS) begin
            if (!mid_pause_done && planned_items >= 150) begin
                plan_drain_pause();
                mid_pause_done = 1'b1;
            end
            mode = $urandom_range(0, 9);
            case (mode)
                0, 1: begin
                    while (plan_level < CAP) plan_random(any_push());
                    repeat ($urandom_range(1, 2)) plan_random(any_push());
                    plan_random(any_dump());
                end
                2, 3: begin
                    while (plan_level > 0) plan_random(any_pop());
                    plan_random(any_pop());
                end
                4: plan_random(any_dump());
                9: plan_random($urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B);
                default: begin
                    repeat ($urandom_range(1, 8))
                        plan_random(OP_W'($urandom_range(OP_PUSH_FRONT, OP_DUMP_BWD)));
                end
            endcase
        end

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Wait for the plan to empty and every result to arrive
        do @(posedge aclk);
        while (cmd_plan.size() != 0 || s_valid || awaited_results.size() != 0);
        repeat (2 * CAP + 10) @(posedge aclk);

        if (mismatches == 0 && awaited_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Give up on a hung run
    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
